// File: rtl/brars_pkg.sv
// Package for the blocked range-add / range-sum engine.
// Field widths, mode codes, block store entry type and sequencer states.
// No dependencies.
package brars_pkg;

    localparam int MODE_W  = 2;
    localparam int INDEX_W = 10;
    localparam int VALUE_W = 32;
    localparam int DATA_W  = 64;

    localparam int ELEMENTS_DEF  = 1024;
    localparam int BLOCK_LEN_DEF = 32;

    localparam logic [MODE_W-1:0] MODE_LOAD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ADD   = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd2;

    typedef struct packed {
        logic [DATA_W-1:0] sum;
        logic [DATA_W-1:0] tag;
    } blk_ent_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_LD_RD,
        ST_LD_WR,
        ST_PB_RD,
        ST_PB_EL,
        ST_PB_DRAIN,
        ST_PB_WB,
        ST_INNER,
        ST_INNER_DRAIN,
        ST_OUT
    } state_t;

endpackage

// File: rtl/blocked_range_add_range_sum_top.sv
// Blocked range-add / range-sum engine: element memory plus block memory (sum, tag).
// Depends on brars_pkg.
//
//  channel | direction | handshake        | payload
//  s_      | in        | s_valid/s_ready  | s_mode, s_left, s_right, s_value
//  m_      | out       | m_valid/m_ready  | m_range_sum (queries only)
//
// One item at a time; each memory has a single read port. Steps: accept, block index;
// per end block a block read, a walk over its partial elements, a drain and a write-back
// when adding; then the inner blocks and a drain if any; then ST_OUT on a query.
// A load reads, then writes both memories; an empty range or unused mode returns to idle.
// After reset a clearing pass zeroes both memories; s_ready is low.
// A finished query result waits in the output register; the next beat is accepted
// meanwhile, and a later query holds in ST_OUT until the register is free.
module blocked_range_add_range_sum_top #(
    parameter int ELEMENTS  = brars_pkg::ELEMENTS_DEF,
    parameter int BLOCK_LEN = brars_pkg::BLOCK_LEN_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic        [brars_pkg::MODE_W-1:0]  s_mode,
    input  logic        [brars_pkg::INDEX_W-1:0] s_left,
    input  logic        [brars_pkg::INDEX_W-1:0] s_right,
    input  logic signed [brars_pkg::VALUE_W-1:0] s_value,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [brars_pkg::DATA_W-1:0]  m_range_sum
);
    import brars_pkg::*;

    localparam int NUM_BLOCKS = (ELEMENTS + BLOCK_LEN - 1) / BLOCK_LEN;
    localparam int AW   = $clog2(ELEMENTS);
    localparam int BW   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CMPW = ((AW > INDEX_W) ? AW : INDEX_W) + 1;
    // block index by reciprocal multiply: exact for every AW-bit index
    localparam int     RSH     = AW + $clog2(BLOCK_LEN);
    localparam int     MW      = AW + 1;
    localparam longint RECIP_L = ((longint'(1) << RSH) + longint'(BLOCK_LEN) - longint'(1))
                                 / longint'(BLOCK_LEN);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);

    // memories
    logic [DATA_W-1:0] el_mem  [ELEMENTS];
    blk_ent_t          blk_mem [NUM_BLOCKS];

    logic              el_rd_en, el_wr_en, blk_rd_en, blk_wr_en;
    logic [AW-1:0]     el_rd_addr, el_wr_addr;
    logic [BW-1:0]     blk_rd_addr, blk_wr_addr;
    logic [DATA_W-1:0] el_wr_data;
    blk_ent_t          blk_wr_data;

    // registers
    state_t            state_reg, state_next;
    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [AW-1:0]     lo_reg, lo_next, hi_reg, hi_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [BW-1:0]     q_lo_reg, q_lo_next, q_hi_reg, q_hi_next;
    logic              seg_reg, seg_next;
    logic              first_reg, first_next;
    logic [AW-1:0]     el_ptr_reg, el_ptr_next, el_end_reg, el_end_next;
    logic              p_vld_reg, p_vld_next;
    logic [AW-1:0]     p_addr_reg, p_addr_next;
    logic [DATA_W-1:0] bsum_reg, bsum_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic [BW-1:0]     ib_ptr_reg, ib_ptr_next;
    logic              i_vld_reg, i_vld_next;
    logic [BW-1:0]     i_addr_reg, i_addr_next;
    logic              j_vld_reg, j_vld_next;
    logic [DATA_W-1:0] prod_reg, prod_next, isum_reg, isum_next;
    logic              m_valid_reg, m_valid_next;
    logic [DATA_W-1:0] m_sum_reg, m_sum_next;
    logic [AW-1:0]     clr_ptr_reg, clr_ptr_next;
    logic [DATA_W-1:0] el_rdata_reg;
    blk_ent_t          blk_rdata_reg;

    // decode at the input beat
    logic [CMPW-1:0] lo_ext, hi_ext;
    logic [AW-1:0]   hi_clip;
    logic            lo_ok, range_ok, s_fire;

    assign s_fire  = s_valid && s_ready;
    assign lo_ext  = CMPW'(s_left);
    assign hi_ext  = CMPW'(s_right);
    assign hi_clip = (hi_ext >= CMPW'(ELEMENTS)) ? AW'(ELEMENTS - 1) : AW'(s_right);
    assign lo_ok    = lo_ext < CMPW'(ELEMENTS);
    assign range_ok = lo_ok && (lo_ext <= CMPW'(hi_clip));

    // sequencer conditions
    logic          el_last, more_seg, has_inner, ib_last, is_add, is_query;
    logic [BW-1:0] ib_end;
    logic          clr_last;

    assign is_add    = mode_reg == MODE_ADD;
    assign is_query  = mode_reg == MODE_QUERY;
    assign el_last   = el_ptr_reg == el_end_reg;
    assign more_seg  = !seg_reg && (q_lo_reg != q_hi_reg);
    assign has_inner = {1'b0, q_hi_reg} >= ({1'b0, q_lo_reg} + (BW+1)'(2));
    assign ib_end    = q_hi_reg - BW'(1);
    assign ib_last   = ib_ptr_reg == ib_end;
    assign clr_last  = clr_ptr_reg == AW'(ELEMENTS - 1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    case (s_mode)
                        MODE_LOAD:  state_next = lo_ok ? ST_DIV : ST_IDLE;
                        MODE_ADD:   state_next = range_ok ? ST_DIV : ST_IDLE;
                        MODE_QUERY: state_next = range_ok ? ST_DIV : ST_OUT;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_DIV: begin
                state_next = (mode_reg == MODE_LOAD) ? ST_LD_RD : ST_PB_RD;
            end
            ST_LD_RD:    state_next = ST_LD_WR;
            ST_LD_WR:    state_next = ST_IDLE;
            ST_PB_RD:    state_next = ST_PB_EL;
            ST_PB_EL: begin
                if (el_last) state_next = ST_PB_DRAIN;
            end
            ST_PB_DRAIN: state_next = ST_PB_WB;
            ST_PB_WB: begin
                if (more_seg)       state_next = ST_PB_RD;
                else if (has_inner) state_next = ST_INNER;
                else                state_next = is_query ? ST_OUT : ST_IDLE;
            end
            ST_INNER: begin
                if (ib_last) state_next = ST_INNER_DRAIN;
            end
            ST_INNER_DRAIN: begin
                if (!i_vld_reg && !j_vld_reg) state_next = is_query ? ST_OUT : ST_IDLE;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake and memory port controls
    always_comb begin
        s_ready     = state_reg == ST_IDLE;
        el_rd_en    = 1'b0;
        el_rd_addr  = el_ptr_reg;
        el_wr_en    = 1'b0;
        el_wr_addr  = p_addr_reg;
        el_wr_data  = el_rdata_reg + val_reg;
        blk_rd_en   = 1'b0;
        blk_rd_addr = ib_ptr_reg;
        blk_wr_en   = 1'b0;
        blk_wr_addr = i_addr_reg;
        blk_wr_data = '{sum: blk_rdata_reg.sum, tag: blk_rdata_reg.tag + val_reg};
        case (state_reg)
            ST_CLEAR: begin
                el_wr_en    = 1'b1;
                el_wr_addr  = clr_ptr_reg;
                el_wr_data  = '0;
                blk_wr_en   = {1'b0, clr_ptr_reg} < (AW+1)'(NUM_BLOCKS);
                blk_wr_addr = clr_ptr_reg[BW-1:0];
                blk_wr_data = '0;
            end
            ST_LD_RD: begin
                el_rd_en    = 1'b1;
                el_rd_addr  = lo_reg;
                blk_rd_en   = 1'b1;
                blk_rd_addr = q_lo_reg;
            end
            ST_LD_WR: begin
                el_wr_en    = 1'b1;
                el_wr_addr  = lo_reg;
                el_wr_data  = val_reg;
                blk_wr_en   = 1'b1;
                blk_wr_addr = q_lo_reg;
                blk_wr_data = '{sum: blk_rdata_reg.sum + val_reg - el_rdata_reg,
                                tag: blk_rdata_reg.tag};
            end
            ST_PB_RD: begin
                blk_rd_en   = 1'b1;
                blk_rd_addr = seg_reg ? q_hi_reg : q_lo_reg;
            end
            ST_PB_EL: begin
                el_rd_en = 1'b1;
                el_wr_en = p_vld_reg && is_add;
            end
            ST_PB_DRAIN: begin
                el_wr_en = p_vld_reg && is_add;
            end
            ST_PB_WB: begin
                blk_wr_en   = is_add;
                blk_wr_addr = seg_reg ? q_hi_reg : q_lo_reg;
                blk_wr_data = '{sum: bsum_reg, tag: blk_rdata_reg.tag};
            end
            ST_INNER: begin
                blk_rd_en = 1'b1;
                blk_wr_en = i_vld_reg && is_add;
            end
            ST_INNER_DRAIN: begin
                blk_wr_en = i_vld_reg && is_add;
            end
            default: begin
            end
        endcase
    end

    // datapath
    logic [AW+MW-1:0] qp_lo, qp_hi;
    logic [AW-1:0]    base_lo, base_hi;
    logic [AW:0]      end0;

    assign qp_lo   = (AW+MW)'(lo_reg) * (AW+MW)'(RECIP);
    assign qp_hi   = (AW+MW)'(hi_reg) * (AW+MW)'(RECIP);
    // first index of each end block
    assign base_lo = AW'(q_lo_reg) * AW'(BLOCK_LEN);
    assign base_hi = AW'(q_hi_reg) * AW'(BLOCK_LEN);
    // last index of the first block
    assign end0    = {1'b0, base_lo} + (AW+1)'(BLOCK_LEN - 1);

    always_comb begin
        mode_next    = mode_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        val_next     = val_reg;
        q_lo_next    = q_lo_reg;
        q_hi_next    = q_hi_reg;
        seg_next     = seg_reg;
        first_next   = 1'b0;
        el_ptr_next  = el_ptr_reg;
        el_end_next  = el_end_reg;
        p_vld_next   = 1'b0;
        p_addr_next  = el_ptr_reg;
        bsum_next    = bsum_reg;
        acc_next     = acc_reg;
        ib_ptr_next  = ib_ptr_reg;
        i_vld_next   = 1'b0;
        i_addr_next  = ib_ptr_reg;
        j_vld_next   = i_vld_reg && is_query;
        prod_next    = blk_rdata_reg.tag * DATA_W'(BLOCK_LEN);
        isum_next    = blk_rdata_reg.sum;
        m_valid_next = m_valid_reg && !m_ready;
        m_sum_next   = m_sum_reg;
        clr_ptr_next = clr_ptr_reg;

        if (state_reg == ST_CLEAR) clr_ptr_next = clr_ptr_reg + AW'(1);

        if (s_fire) begin
            mode_next   = s_mode;
            lo_next     = AW'(s_left);
            hi_next     = hi_clip;
            val_next    = {{(DATA_W-VALUE_W){s_value[VALUE_W-1]}}, s_value};
            q_lo_next   = '0;
            q_hi_next   = '0;
            seg_next    = 1'b0;
            acc_next    = '0;
        end

        if (state_reg == ST_DIV) begin
            q_lo_next = BW'(qp_lo >> RSH);
            q_hi_next = BW'(qp_hi >> RSH);
        end

        if (state_reg == ST_PB_RD) begin
            first_next = 1'b1;
            if (seg_reg) begin
                el_ptr_next = base_hi;
                el_end_next = hi_reg;
            end else begin
                el_ptr_next = lo_reg;
                el_end_next = (q_lo_reg == q_hi_reg) ? hi_reg : end0[AW-1:0];
            end
        end

        if (state_reg == ST_PB_EL) begin
            p_vld_next  = 1'b1;
            el_ptr_next = el_ptr_reg + AW'(1);
            if (first_reg) bsum_next = blk_rdata_reg.sum;
        end

        // element data back from memory
        if (p_vld_reg) begin
            if (is_add) bsum_next = bsum_reg + val_reg;
            else        acc_next  = acc_reg + el_rdata_reg + blk_rdata_reg.tag;
        end

        if (state_reg == ST_PB_WB) begin
            seg_next    = 1'b1;
            ib_ptr_next = q_lo_reg + BW'(1);
        end

        if (state_reg == ST_INNER) begin
            i_vld_next  = 1'b1;
            ib_ptr_next = ib_ptr_reg + BW'(1);
        end

        if (j_vld_reg) acc_next = acc_reg + isum_reg + prod_reg;

        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
            m_sum_next   = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            clr_ptr_reg <= '0;
            p_vld_reg   <= 1'b0;
            i_vld_reg   <= 1'b0;
            j_vld_reg   <= 1'b0;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_ptr_reg <= clr_ptr_next;
            p_vld_reg   <= p_vld_next;
            i_vld_reg   <= i_vld_next;
            j_vld_reg   <= j_vld_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        val_reg    <= val_next;
        q_lo_reg   <= q_lo_next;
        q_hi_reg   <= q_hi_next;
        seg_reg    <= seg_next;
        el_ptr_reg <= el_ptr_next;
        el_end_reg <= el_end_next;
        p_addr_reg <= p_addr_next;
        bsum_reg   <= bsum_next;
        acc_reg    <= acc_next;
        ib_ptr_reg <= ib_ptr_next;
        i_addr_reg <= i_addr_next;
        prod_reg   <= prod_next;
        isum_reg   <= isum_next;
        m_sum_reg  <= m_sum_next;
    end

    // element memory
    always_ff @(posedge aclk) begin
        if (el_wr_en) el_mem[el_wr_addr] <= el_wr_data;
        if (el_rd_en) el_rdata_reg <= el_mem[el_rd_addr];
    end

    // block memory: sum and pending tag side by side
    always_ff @(posedge aclk) begin
        if (blk_wr_en) blk_mem[blk_wr_addr] <= blk_wr_data;
        if (blk_rd_en) blk_rdata_reg <= blk_mem[blk_rd_addr];
    end

    assign m_valid     = m_valid_reg;
    assign m_range_sum = m_sum_reg;

endmodule
